// ===== hdl/greedy_mask_quad_merge_core_defines.svh =====
// assertion macros for the greedy mask quad merge block
`ifndef GREEDY_MASK_QUAD_MERGE_CORE_DEFINES_SVH
`define GREEDY_MASK_QUAD_MERGE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GMQM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gmqm check failed");

// next-cycle implication, disabled during reset
`define GMQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gmqm check failed");

`endif

// ===== hdl/gmqm_pkg.sv =====
// shared constants for the greedy mask quad merge block
package gmqm_pkg;

   localparam int SIDE_DEFAULT = 16;
   localparam int ROW_INDEX_W  = 4;
   localparam int ROW_BITS_W   = 16;
   localparam int COL_W        = 4;
   localparam int EXT_W        = 5;

endpackage

// ===== hdl/gmqm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module gmqm_ram #(
   parameter int WIDTH = gmqm_pkg::SIDE_DEFAULT,
   parameter int DEPTH = gmqm_pkg::SIDE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/greedy_mask_quad_merge_core.sv =====
// greedy rectangle decomposition of a square binary mask, top level
//
// usage: one command channel (start/busy with req_ ports) and one result
// channel (rsp_valid strobe with rsp_ ports). a command is taken at a clock
// edge with start high and busy low. every command gives exactly one result,
// shown for a single cycle while rsp_valid is high; the receiver cannot
// stall, so results are never held back.
// a load (req_action 0) writes one mask row and rewinds the scan cursor;
// its all-zero result follows in the cycle after the transfer and busy stays low.
// a fetch (req_action 1) walks the mask one ram row per cycle: the scan reads
// rows from the cursor to one with a set bit, the width state sizes the quad,
// the height check reads the rows below it while they cover its span, and the
// finish state forms the result; a scan that finds no set bit gives a done
// result. scan rows and height rows together never pass SIDE. busy falls as
// the result strobe rises, so the next transfer may share the edge that takes
// the result.
// reset (synchronous, active high) clears the mask through per-row valid
// bits, rewinds the cursor and drops any command in progress; no clearing
// pass is needed.
module greedy_mask_quad_merge_core #(
   parameter int SIDE = gmqm_pkg::SIDE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [gmqm_pkg::ROW_INDEX_W-1:0]   req_row_index,
   input  logic [gmqm_pkg::ROW_BITS_W-1:0]    req_row_bits,
   output logic                               rsp_valid,
   output logic                               rsp_quad_found,
   output logic                               rsp_scan_done,
   output logic [gmqm_pkg::COL_W-1:0]         rsp_quad_col,
   output logic [gmqm_pkg::COL_W-1:0]         rsp_quad_row,
   output logic [gmqm_pkg::EXT_W-1:0]         rsp_quad_width,
   output logic [gmqm_pkg::EXT_W-1:0]         rsp_quad_height
);
   import gmqm_pkg::*;

   localparam int IW = $clog2(SIDE);
   localparam int NW = $clog2(SIDE + 1);
   localparam logic [SIDE:0]   ONE_W    = (SIDE + 1)'(1);
   localparam logic [IW-1:0]   LAST_IDX = IW'(SIDE - 1);
   localparam logic [NW-1:0]   SIDE_N   = NW'(SIDE);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_WIDTH  = 5'b00100,
      ST_HEIGHT = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [IW-1:0]   cur_row_ff, cur_row_in;
   logic [IW-1:0]   cur_col_ff, cur_col_in;
   logic [IW-1:0]   rd_addr_ff;
   logic [IW-1:0]   r_ff, r_in;
   logic [IW-1:0]   c_ff, c_in;
   logic [SIDE-1:0] row_ff, row_in;
   logic [SIDE-1:0] span_ff, span_in;
   logic [NW-1:0]   zi_ff, zi_in;
   logic [NW-1:0]   h_ff, h_in;
   logic [SIDE-1:0] valid_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, found_in;
   logic              done_ff, done_in;
   logic [COL_W-1:0]  qcol_ff, qcol_in;
   logic [COL_W-1:0]  qrow_ff, qrow_in;
   logic [EXT_W-1:0]  qw_ff, qw_in;
   logic [EXT_W-1:0]  qh_ff, qh_in;

   logic            ram_we, ram_re;
   logic [IW-1:0]   ram_wa, ram_ra;
   logic [SIDE-1:0] ram_wd, ram_rd;
   logic [SIDE-1:0] row_data;

   logic [SIDE:0]   lo_c_w;
   logic [SIDE-1:0] rest;
   logic [IW-1:0]   rest_first;
   logic [SIDE:0]   gap;
   logic [NW-1:0]   gap_first;
   logic [SIDE:0]   lo_z_w;
   logic [SIDE-1:0] span_new;
   logic [NW-1:0]   quad_w;
   logic            idx_ok;

   gmqm_ram #(
      .WIDTH (SIDE),
      .DEPTH (SIDE)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign row_data = valid_ff[rd_addr_ff] ? ram_rd : '0;
   assign busy     = (state_ff != ST_IDLE);
   assign idx_ok   = (int'(req_row_index) < SIDE);

   // column masks and first-set searches
   always_comb begin
      lo_c_w     = (ONE_W << c_ff) - ONE_W;
      rest       = row_data & ~lo_c_w[SIDE-1:0];
      rest_first = '0;
      for (int i = SIDE - 1; i >= 0; i--) begin
         if (rest[i]) begin
            rest_first = IW'(i);
         end
      end
      gap       = ~{1'b0, row_ff} & ~lo_c_w;
      gap_first = SIDE_N;
      for (int i = SIDE; i >= 0; i--) begin
         if (gap[i]) begin
            gap_first = NW'(i);
         end
      end
      lo_z_w   = (ONE_W << gap_first) - ONE_W;
      span_new = lo_z_w[SIDE-1:0] & ~lo_c_w[SIDE-1:0];
      quad_w   = zi_ff - NW'(c_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      row_in       = row_ff;
      span_in      = span_ff;
      zi_in        = zi_ff;
      h_in         = h_ff;
      rsp_valid_in = 1'b0;
      found_in     = found_ff;
      done_in      = done_ff;
      qcol_in      = qcol_ff;
      qrow_in      = qrow_ff;
      qw_in        = qw_ff;
      qh_in        = qh_ff;
      ram_we       = 1'b0;
      ram_wa       = rd_addr_ff;
      ram_wd       = '0;
      ram_re       = 1'b0;
      ram_ra       = rd_addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!req_action) begin
                  ram_we       = idx_ok;
                  ram_wa       = IW'(req_row_index);
                  ram_wd       = SIDE'(req_row_bits);
                  cur_row_in   = '0;
                  cur_col_in   = '0;
                  rsp_valid_in = 1'b1;
                  found_in     = 1'b0;
                  done_in      = 1'b0;
                  qcol_in      = '0;
                  qrow_in      = '0;
                  qw_in        = '0;
                  qh_in        = '0;
               end else begin
                  ram_re   = 1'b1;
                  ram_ra   = cur_row_ff;
                  c_in     = cur_col_ff;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rest != '0) begin
               row_in   = row_data;
               c_in     = rest_first;
               r_in     = rd_addr_ff;
               state_in = ST_WIDTH;
            end else if (rd_addr_ff == LAST_IDX) begin
               cur_row_in   = '0;
               cur_col_in   = '0;
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               done_in      = 1'b1;
               qcol_in      = '0;
               qrow_in      = '0;
               qw_in        = '0;
               qh_in        = '0;
               state_in     = ST_IDLE;
            end else begin
               ram_re = 1'b1;
               ram_ra = rd_addr_ff + IW'(1);
               c_in   = '0;
            end
         end
         ST_WIDTH: begin
            span_in = span_new;
            zi_in   = gap_first;
            h_in    = NW'(1);
            ram_we  = 1'b1;
            ram_wa  = r_ff;
            ram_wd  = row_ff & ~span_new;
            if (r_ff != LAST_IDX) begin
               ram_re   = 1'b1;
               ram_ra   = r_ff + IW'(1);
               state_in = ST_HEIGHT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_HEIGHT: begin
            if ((row_data & span_ff) == span_ff) begin
               ram_we = 1'b1;
               ram_wa = rd_addr_ff;
               ram_wd = row_data & ~span_ff;
               h_in   = h_ff + NW'(1);
               if (rd_addr_ff != LAST_IDX) begin
                  ram_re = 1'b1;
                  ram_ra = rd_addr_ff + IW'(1);
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            found_in     = 1'b1;
            done_in      = 1'b0;
            qcol_in      = COL_W'(c_ff);
            qrow_in      = COL_W'(r_ff);
            qw_in        = EXT_W'(quad_w);
            qh_in        = EXT_W'(h_ff);
            if (zi_ff == SIDE_N) begin
               cur_col_in = '0;
               cur_row_in = (r_ff == LAST_IDX) ? '0 : r_ff + IW'(1);
            end else begin
               cur_col_in = IW'(zi_ff);
               cur_row_in = r_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_we) begin
            valid_ff[ram_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         rd_addr_ff <= ram_ra;
      end
      r_ff     <= r_in;
      c_ff     <= c_in;
      row_ff   <= row_in;
      span_ff  <= span_in;
      zi_ff    <= zi_in;
      h_ff     <= h_in;
      found_ff <= found_in;
      done_ff  <= done_in;
      qcol_ff  <= qcol_in;
      qrow_ff  <= qrow_in;
      qw_ff    <= qw_in;
      qh_ff    <= qh_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quad_found  = found_ff;
   assign rsp_scan_done   = done_ff;
   assign rsp_quad_col    = qcol_ff;
   assign rsp_quad_row    = qrow_ff;
   assign rsp_quad_width  = qw_ff;
   assign rsp_quad_height = qh_ff;

endmodule

// ===== hdl/gmqm_checker.sv =====
// port-level checks for the greedy mask quad merge block, with bind
`include "greedy_mask_quad_merge_core_defines.svh"

module gmqm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_action,
   input logic                       rsp_valid,
   input logic                       rsp_quad_found,
   input logic                       rsp_scan_done,
   input logic [gmqm_pkg::COL_W-1:0] rsp_quad_col,
   input logic [gmqm_pkg::COL_W-1:0] rsp_quad_row,
   input logic [gmqm_pkg::EXT_W-1:0] rsp_quad_width,
   input logic [gmqm_pkg::EXT_W-1:0] rsp_quad_height
);
   import gmqm_pkg::*;

   logic load_xfer;
   logic fetch_xfer;
   logic load_rsp;
   logic done_rsp;
   logic empty_fields;

   assign load_xfer    = start && !busy && !req_action;
   assign fetch_xfer   = start && !busy && req_action;
   assign load_rsp     = rsp_valid && !rsp_quad_found && !rsp_scan_done;
   assign done_rsp     = rsp_valid && rsp_scan_done;
   assign empty_fields = (rsp_quad_col == '0) && (rsp_quad_row == '0) &&
                         (rsp_quad_width == '0) && (rsp_quad_height == '0);

   `GMQM_ASSERT_NEXT(a_load_answers_next, clock, reset, load_xfer, load_rsp)
   `GMQM_ASSERT_NEXT(a_fetch_goes_busy, clock, reset, fetch_xfer, busy && !rsp_valid)
   `GMQM_ASSERT_NOW(a_busy_ends_with_result, clock, reset, $fell(busy), rsp_valid)
   `GMQM_ASSERT_NOW(a_found_xor_done, clock, reset, rsp_valid, !(rsp_quad_found && rsp_scan_done))
   `GMQM_ASSERT_NOW(a_done_is_empty, clock, reset, done_rsp, empty_fields)

endmodule

bind greedy_mask_quad_merge_core gmqm_checker u_gmqm_checker (.*);

// ===== tb/tb_greedy_mask_quad_merge_core.sv =====
// self-checking testbench for greedy_mask_quad_merge_core: directed and random mask scans
module tb_greedy_mask_quad_merge_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gmqm_pkg::*;

   localparam int SIDE           = SIDE_DEFAULT;
   localparam int RANDOM_ITEMS   = 800;
   localparam int DRAIN_CYCLES   = 2 * SIDE + 8;
   localparam int WATCHDOG_LIMIT = 20 * (2 * SIDE + 8);
   localparam logic [ROW_BITS_W-1:0] ROW_KEEP =
      (SIDE >= ROW_BITS_W) ? '1 : ROW_BITS_W'((1 << SIDE) - 1);

   typedef enum logic {ACT_LOAD = 1'b0, ACT_FETCH = 1'b1} action_type;
   typedef enum int {PAT_RANDOM, PAT_FULL, PAT_SPARSE, PAT_DENSE, PAT_BAND} pattern_type;

   typedef struct packed {
      logic             found;
      logic             done;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] row;
      logic [EXT_W-1:0] width;
      logic [EXT_W-1:0] height;
   } quad_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_action = ACT_LOAD;
   logic [ROW_INDEX_W-1:0] req_row_index = '0;
   logic [ROW_BITS_W-1:0]  req_row_bits = '0;
   logic                   rsp_valid;
   logic                   rsp_quad_found;
   logic                   rsp_scan_done;
   logic [COL_W-1:0]       rsp_quad_col;
   logic [COL_W-1:0]       rsp_quad_row;
   logic [EXT_W-1:0]       rsp_quad_width;
   logic [EXT_W-1:0]       rsp_quad_height;

   // mirror of the block state
   logic [ROW_BITS_W-1:0] mask_model [SIDE];
   int                    cur_row;
   int                    cur_col;

   quad_rsp_type pending_quads[$];
   bit           idle_en;
   int           band_lo;
   int           band_hi;
   int           n_items;
   int           n_loads;
   int           n_quads;
   int           n_empty;
   int           widest;
   int           tallest;
   int           mismatches;
   int           quiet_cycles;

   greedy_mask_quad_merge_core #(.SIDE(SIDE)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_row_index   (req_row_index),
      .req_row_bits    (req_row_bits),
      .rsp_valid       (rsp_valid),
      .rsp_quad_found  (rsp_quad_found),
      .rsp_scan_done   (rsp_scan_done),
      .rsp_quad_col    (rsp_quad_col),
      .rsp_quad_row    (rsp_quad_row),
      .rsp_quad_width  (rsp_quad_width),
      .rsp_quad_height (rsp_quad_height)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic quad_rsp_type next_quad(action_type act,
                                              logic [ROW_INDEX_W-1:0] idx,
                                              logic [ROW_BITS_W-1:0] bits);
      quad_rsp_type          q;
      logic [ROW_BITS_W-1:0] span;
      int                    r, c, w, h, rr, cc, k;
      bit                    hit;
      q = '0;
      if (act == ACT_LOAD) begin
         if (int'(idx) < SIDE) mask_model[idx] = bits & ROW_KEEP;
         cur_row = 0;
         cur_col = 0;
         return q;
      end
      hit = 1'b0;
      r = 0;
      c = 0;
      for (rr = cur_row; rr < SIDE && !hit; rr++) begin
         for (cc = (rr == cur_row) ? cur_col : 0; cc < SIDE && !hit; cc++) begin
            if (mask_model[rr][cc]) begin
               hit = 1'b1;
               r = rr;
               c = cc;
            end
         end
      end
      if (!hit) begin
         cur_row = 0;
         cur_col = 0;
         q.done = 1'b1;
         return q;
      end
      w = 1;
      while (c + w < SIDE && mask_model[r][c + w]) w++;
      span = '0;
      for (k = c; k < c + w; k++) span[k] = 1'b1;
      h = 1;
      while (r + h < SIDE && (mask_model[r + h] & span) == span) h++;
      for (k = 0; k < h; k++) mask_model[r + k] &= ~span;
      if (c + w >= SIDE) begin
         cur_col = 0;
         cur_row = (r + 1 >= SIDE) ? 0 : r + 1;
      end else begin
         cur_col = c + w;
         cur_row = r;
      end
      q.found  = 1'b1;
      q.col    = COL_W'(c);
      q.row    = COL_W'(r);
      q.width  = EXT_W'(w);
      q.height = EXT_W'(h);
      return q;
   endfunction

   function automatic logic [ROW_BITS_W-1:0] row_pattern(pattern_type pat);
      logic [ROW_BITS_W-1:0] v;
      int                    k;
      case (pat)
         PAT_RANDOM: v = ROW_BITS_W'($urandom);
         PAT_FULL:   v = '1;
         PAT_SPARSE: v = ROW_BITS_W'($urandom & $urandom & $urandom);
         PAT_DENSE:  v = ROW_BITS_W'($urandom | $urandom);
         default: begin
            v = '0;
            for (k = band_lo; k <= band_hi; k++) v[k] = 1'b1;
         end
      endcase
      return v;
   endfunction

   function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input action_type act, input logic [ROW_INDEX_W-1:0] idx,
                            input logic [ROW_BITS_W-1:0] bits, output quad_rsp_type pred);
      int gap;
      gap = idle_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_row_index <= idx;
      req_row_bits  <= bits;
      do @(posedge clock); while (busy);
      pred = next_quad(act, idx, bits);
      pending_quads.insert(pending_quads.size(), pred);
      n_items++;
      @(negedge clock);
   endtask

   task automatic load_row(input int idx, input logic [ROW_BITS_W-1:0] bits);
      quad_rsp_type pred;
      send_item(ACT_LOAD, ROW_INDEX_W'(idx), bits, pred);
   endtask

   task automatic fetch_quad(output quad_rsp_type pred);
      send_item(ACT_FETCH, ROW_INDEX_W'($urandom), ROW_BITS_W'($urandom), pred);
   endtask

   task automatic drain_scan();
      quad_rsp_type pred;
      do fetch_quad(pred); while (!pred.done);
   endtask

   task automatic test_empty_scan();
      quad_rsp_type pred;
      fetch_quad(pred);
   endtask

   task automatic test_full_square();
      int r;
      for (r = 0; r < SIDE; r++) load_row(r, '1);
      drain_scan();
   endtask

   task automatic test_corner_cells();
      load_row(0, 16'h8001);
      load_row(SIDE - 1, 16'h8000);
      drain_scan();
   endtask

   task automatic test_random_frames();
      quad_rsp_type pred;
      pattern_type  pat;
      int           stop_at, kind, n, i;
      stop_at = n_items + RANDOM_ITEMS;
      while (n_items < stop_at) begin
         pat     = pattern_type'($urandom_range(0, 4));
         idle_en = ($urandom_range(0, 3) != 0);
         band_lo = $urandom_range(0, SIDE - 1);
         band_hi = $urandom_range(band_lo, SIDE - 1);
         kind    = $urandom_range(0, 9);
         if (kind == 0) begin
            // noise
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
               send_item(action_type'($urandom_range(0, 1)), ROW_INDEX_W'($urandom),
                         ROW_BITS_W'($urandom), pred);
         end else if (kind == 1) begin
            // scan cut short, then rewound by a load
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) load_row($urandom_range(0, SIDE - 1), row_pattern(pat));
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) fetch_quad(pred);
            load_row($urandom_range(0, SIDE - 1), row_pattern(pat));
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) fetch_quad(pred);
         end else begin
            if ($urandom_range(0, 1) == 0) begin
               for (i = 0; i < SIDE; i++) begin
                  if ($urandom_range(0, 3) == 0) begin
                     band_lo = $urandom_range(0, SIDE - 1);
                     band_hi = $urandom_range(band_lo, SIDE - 1);
                  end
                  load_row(i, row_pattern(pat));
               end
            end else begin
               n = $urandom_range(1, 20);
               for (i = 0; i < n; i++) load_row($urandom_range(0, SIDE - 1), row_pattern(pat));
            end
            drain_scan();
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      quad_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_quads.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual %h", $time,
                     {rsp_quad_found, rsp_scan_done, rsp_quad_col, rsp_quad_row,
                      rsp_quad_width, rsp_quad_height});
            mismatches++;
         end else begin
            want = pending_quads.pop_front();
            check_field("quad_found", want.found, rsp_quad_found);
            check_field("scan_done", want.done, rsp_scan_done);
            check_field("quad_col", want.col, rsp_quad_col);
            check_field("quad_row", want.row, rsp_quad_row);
            check_field("quad_width", want.width, rsp_quad_width);
            check_field("quad_height", want.height, rsp_quad_height);
            if (want.found) begin
               n_quads++;
               if (want.width > widest) widest = want.width;
               if (want.height > tallest) tallest = want.height;
            end else if (want.done) begin
               n_empty++;
            end else begin
               n_loads++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int r = 0; r < SIDE; r++) mask_model[r] = '0;
      cur_row      = 0;
      cur_col      = 0;
      idle_en      = 1'b1;
      n_items      = 0;
      n_loads      = 0;
      n_quads      = 0;
      n_empty      = 0;
      widest       = 0;
      tallest      = 0;
      mismatches   = 0;
      quiet_cycles = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_scan();
      test_full_square();
      test_corner_cells();
      test_random_frames();

      start <= 1'b0;
      while (pending_quads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands: %0d row loads, %0d quads, %0d empty scans",
               n_items, n_loads, n_quads, n_empty);
      $display("largest quad extents seen: width %0d, height %0d; %0d mismatches",
               widest, tallest, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
